### hw/rtl/fvk_pkg.sv
// fvk_pkg: constants, output widths and the arctangent table of the four-vector
// kinematics pipeline.
// Depends on nothing; imported by four_vector_kinematics and the bench tb.
package fvk_pkg;

    localparam int MAG_W   = 20;
    localparam int ANGLE_W = 17;
    localparam int ETA_W   = 16;
    localparam int MASS_W  = 33;

    localparam int LOG_FRAC = 20;
    localparam int MANT_W   = 31;
    localparam int ZW       = 32;

    localparam logic signed [ZW-1:0] ANGLE_HALF_PI = 32'sd536870912;
    localparam logic [30:0]          ANGLE_PI      = 31'd1073741824;
    localparam logic [29:0]          LN2_Q30       = 30'd744261118;
    localparam logic [ETA_W-1:0]     ETA_MAX       = 16'd32767;

    // atan(2^-i) in units of pi/2^30, rounded
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0:    a = 32'sd268435456;
            5'd1:    a = 32'sd158466703;
            5'd2:    a = 32'sd83729454;
            5'd3:    a = 32'sd42502378;
            5'd4:    a = 32'sd21333666;
            5'd5:    a = 32'sd10677233;
            5'd6:    a = 32'sd5339919;
            5'd7:    a = 32'sd2670123;
            5'd8:    a = 32'sd1335082;
            5'd9:    a = 32'sd667543;
            5'd10:   a = 32'sd333771;
            5'd11:   a = 32'sd166886;
            5'd12:   a = 32'sd83443;
            5'd13:   a = 32'sd41721;
            5'd14:   a = 32'sd20861;
            5'd15:   a = 32'sd10430;
            5'd16:   a = 32'sd5215;
            5'd17:   a = 32'sd2608;
            5'd18:   a = 32'sd1304;
            5'd19:   a = 32'sd652;
            5'd20:   a = 32'sd326;
            5'd21:   a = 32'sd163;
            5'd22:   a = 32'sd81;
            5'd23:   a = 32'sd41;
            5'd24:   a = 32'sd20;
            5'd25:   a = 32'sd10;
            5'd26:   a = 32'sd5;
            5'd27:   a = 32'sd3;
            5'd28:   a = 32'sd1;
            5'd29:   a = 32'sd1;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/four_vector_kinematics.sv
// four_vector_kinematics: |p|, theta, eta and m^2 of one four-vector per word.
// Depends on fvk_pkg.
// Structure: one square-root digit per stage, then one log squaring per stage.
// Throughput: one word per cycle; a stalled valid output freezes the whole pipe.
// Reset: rst_n clears every valid bit asynchronously; payload registers are not reset.
module four_vector_kinematics #(
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COMPONENT_BITS-1:0]      energy_value,
    input  logic signed [COMPONENT_BITS-1:0]      momentum_x,
    input  logic signed [COMPONENT_BITS-1:0]      momentum_y,
    input  logic signed [COMPONENT_BITS-1:0]      momentum_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [fvk_pkg::MAG_W-1:0]             momentum_magnitude,
    output logic [fvk_pkg::ANGLE_W-1:0]           polar_angle,
    output logic signed [fvk_pkg::ETA_W-1:0]      pseudorapidity,
    output logic signed [fvk_pkg::MASS_W-1:0]     mass_squared,
    output logic                                  zero_momentum,
    output logic                                  eta_saturated
);
    import fvk_pkg::*;

    localparam int B    = COMPONENT_BITS;
    localparam int CS   = CORDIC_STEPS;
    localparam int SW   = 2*B + 2;            // sum of squares
    localparam int NI   = B + 1;              // integer root digits
    localparam int NS   = NI + 8;             // root digits incl. 8 fraction bits
    localparam int RW   = NS;                 // root width
    localparam int MW   = 2*B + 3;            // mass difference
    localparam int LW   = RW + 1;             // log argument |p| + |pz|
    localparam int PW   = (LW > MANT_W) ? LW : MANT_W;
    localparam int EW   = $clog2(PW);
    localparam int RESW = EW + LOG_FRAC;      // log2 result
    localparam int PRW  = RESW + 30;          // d * ln2
    localparam int EAW  = PRW + 1 - 38;       // |eta| before clipping
    localparam int CW   = B + 11;             // CORDIC x/y
    localparam int P2   = (CS > LOG_FRAC + 2) ? CS : LOG_FRAC + 2;

    // one digit of the restoring square root: returns {r_next, rem_next}
    function automatic logic [2*RW+1:0] root_step(input logic [RW-1:0] r,
                                                  input logic [RW+1:0] rem,
                                                  input logic [1:0] pair);
        logic [RW+1:0] sh;
        logic [RW+1:0] t;
        logic          ge;
        sh = {rem[RW-1:0], pair};
        t  = {r, 2'b01};
        ge = (sh >= t);
        return {r[RW-2:0], ge, (ge ? (sh - t) : sh)};
    endfunction

    function automatic logic [EW-1:0] lead_one(input logic [PW-1:0] v);
        logic [EW-1:0] e;
        e = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (v[i])
            begin
                e = EW'(i);
            end
        end
        return e;
    endfunction

    // Q1.30 mantissa, leading one at bit 30
    function automatic logic [MANT_W-1:0] mantissa(input logic [PW-1:0] v,
                                                   input logic [EW-1:0] e);
        logic [PW-1:0] n;
        n = v << (EW'(PW-1) - e);
        return n[PW-1 -: MANT_W];
    endfunction

    // Global advance: the pipe moves unless a finished word waits on a stalled output.
    logic adv;
    logic out_valid_reg;

    assign adv      = ~(out_valid_reg & out_stall);
    assign in_stall = ~adv;

    // ------------------------------------------------------------------
    // Stage 1: magnitudes and squares
    // ------------------------------------------------------------------
    logic [B-1:0] raw_e, raw_x, raw_y, raw_z;
    logic [B-1:0] abs_e, abs_x, abs_y, abs_z;

    assign raw_e = energy_value;
    assign raw_x = momentum_x;
    assign raw_y = momentum_y;
    assign raw_z = momentum_z;
    assign abs_e = raw_e[B-1] ? (~raw_e + 1'b1) : raw_e;
    assign abs_x = raw_x[B-1] ? (~raw_x + 1'b1) : raw_x;
    assign abs_y = raw_y[B-1] ? (~raw_y + 1'b1) : raw_y;
    assign abs_z = raw_z[B-1] ? (~raw_z + 1'b1) : raw_z;

    logic           p1_v_reg;
    logic [B-1:0]   p1_az_reg, p1_ax_reg, p1_ay_reg;
    logic           p1_neg_reg;
    logic [2*B-1:0] p1_sqe_reg, p1_sqx_reg, p1_sqy_reg, p1_sqz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ax_reg  <= abs_x;
            p1_ay_reg  <= abs_y;
            p1_az_reg  <= abs_z;
            p1_neg_reg <= raw_z[B-1];
            p1_sqe_reg <= {{B{1'b0}}, abs_e} * {{B{1'b0}}, abs_e};
            p1_sqx_reg <= {{B{1'b0}}, abs_x} * {{B{1'b0}}, abs_x};
            p1_sqy_reg <= {{B{1'b0}}, abs_y} * {{B{1'b0}}, abs_y};
            p1_sqz_reg <= {{B{1'b0}}, abs_z} * {{B{1'b0}}, abs_z};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 (root index 0): sums, exact mass, zero flag.
    // Then one root digit per stage for |p| and pt side by side.
    // ------------------------------------------------------------------
    logic                     sq_v_reg    [0:NS];
    logic [SW-1:0]            sq_s_reg    [0:NS];
    logic [SW-1:0]            sq_st_reg   [0:NS];
    logic [RW-1:0]            sq_rp_reg   [0:NS];
    logic [RW+1:0]            sq_remp_reg [0:NS];
    logic [RW-1:0]            sq_rt_reg   [0:NS];
    logic [RW+1:0]            sq_remt_reg [0:NS];
    logic signed [MASS_W-1:0] sq_mass_reg [0:NS];
    logic                     sq_zero_reg [0:NS];
    logic [B-1:0]             sq_az_reg   [0:NS];
    logic                     sq_neg_reg  [0:NS];

    logic [2*B:0]         st_sum;
    logic [SW-1:0]        s_sum;
    logic signed [MW-1:0] mass_diff;

    assign st_sum    = {1'b0, p1_sqx_reg} + {1'b0, p1_sqy_reg};
    assign s_sum     = {1'b0, st_sum} + {2'b00, p1_sqz_reg};
    assign mass_diff = $signed({3'b000, p1_sqe_reg}) - $signed({1'b0, s_sum});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_s_reg[0]    <= s_sum;
            sq_st_reg[0]   <= {1'b0, st_sum};
            sq_rp_reg[0]   <= '0;
            sq_remp_reg[0] <= '0;
            sq_rt_reg[0]   <= '0;
            sq_remt_reg[0] <= '0;
            sq_mass_reg[0] <= MASS_W'(mass_diff);
            sq_zero_reg[0] <= (p1_ax_reg == '0) && (p1_ay_reg == '0) && (p1_az_reg == '0);
            sq_az_reg[0]   <= p1_az_reg;
            sq_neg_reg[0]  <= p1_neg_reg;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_root
        logic [1:0]      pair_p;
        logic [1:0]      pair_t;
        logic [2*RW+1:0] step_p;
        logic [2*RW+1:0] step_t;

        if (k < NI)
        begin : g_int
            assign pair_p = sq_s_reg[k][2*(NI-1-k) +: 2];
            assign pair_t = sq_st_reg[k][2*(NI-1-k) +: 2];
        end
        else
        begin : g_frac
            assign pair_p = 2'b00;
            assign pair_t = 2'b00;
        end

        assign step_p = root_step(sq_rp_reg[k], sq_remp_reg[k], pair_p);
        assign step_t = root_step(sq_rt_reg[k], sq_remt_reg[k], pair_t);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_s_reg[k+1]    <= sq_s_reg[k];
                sq_st_reg[k+1]   <= sq_st_reg[k];
                sq_rp_reg[k+1]   <= step_p[2*RW+1 -: RW];
                sq_remp_reg[k+1] <= step_p[RW+1:0];
                sq_rt_reg[k+1]   <= step_t[2*RW+1 -: RW];
                sq_remt_reg[k+1] <= step_t[RW+1:0];
                sq_mass_reg[k+1] <= sq_mass_reg[k];
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_az_reg[k+1]   <= sq_az_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle and log section. Index 0 is set up from the roots; each later stage
    // does one CORDIC rotation until CORDIC_STEPS are done and, in parallel, one step
    // of both logs (leading one, normalise, then one squaring per fraction bit).
    // ------------------------------------------------------------------
    logic [RW-1:0]       pq8;
    logic [RW-1:0]       pt;
    logic [B+7:0]        az8;
    logic [LW-1:0]       la_arg;
    logic [RW+MAG_W-1:0] mag_wide;

    assign pq8      = sq_rp_reg[NS];
    assign pt       = sq_rt_reg[NS];
    assign az8      = {sq_az_reg[NS], 8'h00};
    assign la_arg   = {1'b0, pq8} + {{(LW-B-8){1'b0}}, az8};
    assign mag_wide = {{MAG_W{1'b0}}, pq8} >> 4;

    logic                     ph_v_reg    [0:P2];
    logic signed [CW-1:0]     ph_x_reg    [0:P2];
    logic signed [CW-1:0]     ph_y_reg    [0:P2];
    logic signed [ZW-1:0]     ph_z_reg    [0:P2];
    logic [PW-1:0]            ph_la_reg   [0:P2];
    logic [PW-1:0]            ph_lb_reg   [0:P2];
    logic [EW-1:0]            ph_ea_reg   [0:P2];
    logic [EW-1:0]            ph_eb_reg   [0:P2];
    logic [MANT_W-1:0]        ph_ma_reg   [0:P2];
    logic [MANT_W-1:0]        ph_mb_reg   [0:P2];
    logic [LOG_FRAC-1:0]      ph_fa_reg   [0:P2];
    logic [LOG_FRAC-1:0]      ph_fb_reg   [0:P2];
    logic                     ph_ptz_reg  [0:P2];
    logic                     ph_neg_reg  [0:P2];
    logic                     ph_zero_reg [0:P2];
    logic [MAG_W-1:0]         ph_mag_reg  [0:P2];
    logic signed [MASS_W-1:0] ph_mass_reg [0:P2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            ph_v_reg[0] <= sq_v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_x_reg[0]    <= $signed({{(CW-B-8){1'b0}}, az8});
            ph_y_reg[0]    <= $signed({{(CW-RW){1'b0}}, pt});
            ph_z_reg[0]    <= '0;
            ph_la_reg[0]   <= {{(PW-LW){1'b0}}, la_arg};
            ph_lb_reg[0]   <= {{(PW-RW){1'b0}}, pt};
            ph_ea_reg[0]   <= '0;
            ph_eb_reg[0]   <= '0;
            ph_ma_reg[0]   <= '0;
            ph_mb_reg[0]   <= '0;
            ph_fa_reg[0]   <= '0;
            ph_fb_reg[0]   <= '0;
            ph_ptz_reg[0]  <= (pt == '0);
            ph_neg_reg[0]  <= sq_neg_reg[NS];
            ph_zero_reg[0] <= sq_zero_reg[NS];
            ph_mag_reg[0]  <= mag_wide[MAG_W-1:0];
            ph_mass_reg[0] <= sq_mass_reg[NS];
        end
    end

    for (genvar j = 0; j < P2; j++)
    begin : g_ph
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ph_v_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                ph_v_reg[j+1] <= ph_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ph_la_reg[j+1]   <= ph_la_reg[j];
                ph_lb_reg[j+1]   <= ph_lb_reg[j];
                ph_ptz_reg[j+1]  <= ph_ptz_reg[j];
                ph_neg_reg[j+1]  <= ph_neg_reg[j];
                ph_zero_reg[j+1] <= ph_zero_reg[j];
                ph_mag_reg[j+1]  <= ph_mag_reg[j];
                ph_mass_reg[j+1] <= ph_mass_reg[j];
            end
        end

        // vectoring CORDIC, rotate y towards zero
        if (j < CS)
        begin : g_rot
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic signed [ZW-1:0] at;

            assign xs = ph_x_reg[j] >>> j;
            assign ys = ph_y_reg[j] >>> j;
            assign at = atan_entry(5'(j));

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!ph_y_reg[j][CW-1])
                    begin
                        ph_x_reg[j+1] <= ph_x_reg[j] + ys;
                        ph_y_reg[j+1] <= ph_y_reg[j] - xs;
                        ph_z_reg[j+1] <= ph_z_reg[j] + at;
                    end
                    else
                    begin
                        ph_x_reg[j+1] <= ph_x_reg[j] - ys;
                        ph_y_reg[j+1] <= ph_y_reg[j] + xs;
                        ph_z_reg[j+1] <= ph_z_reg[j] - at;
                    end
                end
            end
        end
        else
        begin : g_rot_pass
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ph_x_reg[j+1] <= ph_x_reg[j];
                    ph_y_reg[j+1] <= ph_y_reg[j];
                    ph_z_reg[j+1] <= ph_z_reg[j];
                end
            end
        end

        if (j == 0)
        begin : g_lead
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ph_ea_reg[j+1] <= lead_one(ph_la_reg[j]);
                    ph_eb_reg[j+1] <= lead_one(ph_lb_reg[j]);
                    ph_ma_reg[j+1] <= ph_ma_reg[j];
                    ph_mb_reg[j+1] <= ph_mb_reg[j];
                    ph_fa_reg[j+1] <= ph_fa_reg[j];
                    ph_fb_reg[j+1] <= ph_fb_reg[j];
                end
            end
        end
        else if (j == 1)
        begin : g_norm
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ph_ea_reg[j+1] <= ph_ea_reg[j];
                    ph_eb_reg[j+1] <= ph_eb_reg[j];
                    ph_ma_reg[j+1] <= mantissa(ph_la_reg[j], ph_ea_reg[j]);
                    ph_mb_reg[j+1] <= mantissa(ph_lb_reg[j], ph_eb_reg[j]);
                    ph_fa_reg[j+1] <= '0;
                    ph_fb_reg[j+1] <= '0;
                end
            end
        end
        else if (j < LOG_FRAC + 2)
        begin : g_square
            // square, keep Q1.30; an overflow past 2 gives a one bit
            logic [2*MANT_W-1:0] sqa;
            logic [2*MANT_W-1:0] sqb;
            logic [MANT_W:0]     qa;
            logic [MANT_W:0]     qb;

            assign sqa = {{MANT_W{1'b0}}, ph_ma_reg[j]} * {{MANT_W{1'b0}}, ph_ma_reg[j]};
            assign sqb = {{MANT_W{1'b0}}, ph_mb_reg[j]} * {{MANT_W{1'b0}}, ph_mb_reg[j]};
            assign qa  = sqa[2*MANT_W-1 -: MANT_W+1];
            assign qb  = sqb[2*MANT_W-1 -: MANT_W+1];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ph_ea_reg[j+1] <= ph_ea_reg[j];
                    ph_eb_reg[j+1] <= ph_eb_reg[j];
                    ph_ma_reg[j+1] <= qa[MANT_W] ? qa[MANT_W:1] : qa[MANT_W-1:0];
                    ph_mb_reg[j+1] <= qb[MANT_W] ? qb[MANT_W:1] : qb[MANT_W-1:0];
                    ph_fa_reg[j+1] <= ph_fa_reg[j]
                                      | (LOG_FRAC'(qa[MANT_W]) << (LOG_FRAC+1-j));
                    ph_fb_reg[j+1] <= ph_fb_reg[j]
                                      | (LOG_FRAC'(qb[MANT_W]) << (LOG_FRAC+1-j));
                end
            end
        end
        else
        begin : g_log_pass
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ph_ea_reg[j+1] <= ph_ea_reg[j];
                    ph_eb_reg[j+1] <= ph_eb_reg[j];
                    ph_ma_reg[j+1] <= ph_ma_reg[j];
                    ph_mb_reg[j+1] <= ph_mb_reg[j];
                    ph_fa_reg[j+1] <= ph_fa_reg[j];
                    ph_fb_reg[j+1] <= ph_fb_reg[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Finish 0: clamp and fold the angle, difference of the two logs
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] z_end;
    logic signed [ZW-1:0] z_clamp;
    logic [30:0]          theta;
    logic [30:0]          theta_rnd;
    logic [RESW-1:0]      log_a;
    logic [RESW-1:0]      log_b;

    assign z_end     = ph_z_reg[P2];
    assign z_clamp   = z_end[ZW-1] ? '0
                     : ((z_end > ANGLE_HALF_PI) ? ANGLE_HALF_PI : z_end);
    assign theta     = ph_neg_reg[P2] ? (ANGLE_PI - z_clamp[30:0]) : z_clamp[30:0];
    assign theta_rnd = theta + 31'd8192;
    assign log_a     = {ph_ea_reg[P2], ph_fa_reg[P2]};
    assign log_b     = {ph_eb_reg[P2], ph_fb_reg[P2]};

    logic                     f0_v_reg;
    logic [ANGLE_W-1:0]       f0_angle_reg;
    logic [RESW-1:0]          f0_d_reg;
    logic                     f0_ptz_reg;
    logic                     f0_neg_reg;
    logic                     f0_zero_reg;
    logic [MAG_W-1:0]         f0_mag_reg;
    logic signed [MASS_W-1:0] f0_mass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f0_v_reg <= ph_v_reg[P2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_angle_reg <= ph_zero_reg[P2] ? '0 : theta_rnd[30:14];
            f0_d_reg     <= (log_a > log_b) ? (log_a - log_b) : '0;
            f0_ptz_reg   <= ph_ptz_reg[P2];
            f0_neg_reg   <= ph_neg_reg[P2];
            f0_zero_reg  <= ph_zero_reg[P2];
            f0_mag_reg   <= ph_mag_reg[P2];
            f0_mass_reg  <= ph_mass_reg[P2];
        end
    end

    // ------------------------------------------------------------------
    // Finish 1: log2 difference times ln2
    // ------------------------------------------------------------------
    logic                     f1_v_reg;
    logic [PRW-1:0]           f1_prod_reg;
    logic [ANGLE_W-1:0]       f1_angle_reg;
    logic                     f1_ptz_reg;
    logic                     f1_neg_reg;
    logic                     f1_zero_reg;
    logic [MAG_W-1:0]         f1_mag_reg;
    logic signed [MASS_W-1:0] f1_mass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_v_reg <= f0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_prod_reg  <= {{30{1'b0}}, f0_d_reg} * {{RESW{1'b0}}, LN2_Q30};
            f1_angle_reg <= f0_angle_reg;
            f1_ptz_reg   <= f0_ptz_reg;
            f1_neg_reg   <= f0_neg_reg;
            f1_zero_reg  <= f0_zero_reg;
            f1_mag_reg   <= f0_mag_reg;
            f1_mass_reg  <= f0_mass_reg;
        end
    end

    // ------------------------------------------------------------------
    // Finish 2 / output register: round, clip to +-32767, apply sign of pz.
    // Momentum along the beam (pt zero) clips straight away.
    // ------------------------------------------------------------------
    logic [PRW:0]       prod_rnd;
    logic [EAW-1:0]     eta_abs;
    logic               eta_clip;
    logic [ETA_W-1:0]   eta_mag;
    logic [ETA_W-1:0]   eta_signed;

    assign prod_rnd   = {1'b0, f1_prod_reg} + ((PRW+1)'(1) << 37);
    assign eta_abs    = prod_rnd[PRW:38];
    assign eta_clip   = f1_ptz_reg || (eta_abs > EAW'(ETA_MAX));
    assign eta_mag    = eta_clip ? ETA_MAX : eta_abs[ETA_W-1:0];
    assign eta_signed = f1_neg_reg ? (~eta_mag + 1'b1) : eta_mag;

    logic [MAG_W-1:0]         out_mag_reg;
    logic [ANGLE_W-1:0]       out_angle_reg;
    logic [ETA_W-1:0]         out_eta_reg;
    logic signed [MASS_W-1:0] out_mass_reg;
    logic                     out_zero_reg;
    logic                     out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_mag_reg   <= f1_zero_reg ? '0 : f1_mag_reg;
            out_angle_reg <= f1_angle_reg;
            out_eta_reg   <= f1_zero_reg ? '0 : eta_signed;
            out_mass_reg  <= f1_mass_reg;
            out_zero_reg  <= f1_zero_reg;
            out_sat_reg   <= ~f1_zero_reg & eta_clip;
        end
    end

    assign out_valid          = out_valid_reg;
    assign momentum_magnitude = out_mag_reg;
    assign polar_angle        = out_angle_reg;
    assign pseudorapidity     = $signed(out_eta_reg);
    assign mass_squared       = out_mass_reg;
    assign zero_momentum      = out_zero_reg;
    assign eta_saturated      = out_sat_reg;

endmodule

### bench/tb.sv
// tb: self-checking bench for four_vector_kinematics (|p|, theta, eta, m^2).
// Depends on fvk_pkg and the four_vector_kinematics RTL; nothing else.
// Directed table first, then random four-vectors checked against a local predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fvk_pkg::*;

    localparam int CB    = 16;
    localparam int STEPS = 16;
    localparam int N_RANDOM = 1930;

    // one expected result word
    typedef struct packed {
        logic [MAG_W-1:0]          mag;
        logic [ANGLE_W-1:0]        angle;
        logic signed [ETA_W-1:0]   eta;
        logic signed [MASS_W-1:0]  mass;
        logic                      zero;
        logic                      sat;
    } kin_t;

    typedef struct {
        logic signed [CB-1:0] e, px, py, pz;
        bit                   has_fixed;  // expected values typed in
        kin_t                 fixed;
    } vec_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CB-1:0] energy_value = '0;
    logic signed [CB-1:0] momentum_x = '0;
    logic signed [CB-1:0] momentum_y = '0;
    logic signed [CB-1:0] momentum_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [MAG_W-1:0] momentum_magnitude;
    logic [ANGLE_W-1:0] polar_angle;
    logic signed [ETA_W-1:0] pseudorapidity;
    logic signed [MASS_W-1:0] mass_squared;
    logic zero_momentum;
    logic eta_saturated;

    kin_t kin_expected[$];
    int   error_count = 0;
    bit   calm_tail = 1'b0;   // no idling near the end
    bit   feeding_done = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    four_vector_kinematics #(.COMPONENT_BITS(CB), .CORDIC_STEPS(STEPS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .energy_value(energy_value), .momentum_x(momentum_x),
        .momentum_y(momentum_y), .momentum_z(momentum_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .momentum_magnitude(momentum_magnitude), .polar_angle(polar_angle),
        .pseudorapidity(pseudorapidity), .mass_squared(mass_squared),
        .zero_momentum(zero_momentum), .eta_saturated(eta_saturated)
    );

    // floor(sqrt(s) * 2^f), digit by digit
    function automatic longint unsigned root_scaled(longint unsigned s, int f);
        longint unsigned r, rem, pair, t;
        r = 0;
        rem = 0;
        for (int k = 0; k < 32 + f; k++)
        begin
            pair = (k < 32) ? ((s >> (2 * (31 - k))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            t = (r << 2) | 64'd1;
            r = r << 1;
            if (rem >= t)
            begin
                rem = rem - t;
                r = r | 64'd1;
            end
        end
        return r;
    endfunction

    // base-2 log with LOG_FRAC fraction bits, mantissa squared and truncated
    function automatic longint unsigned log2_q20(longint unsigned v);
        int e;
        longint unsigned m, res;
        e = 0;
        if (v == 0)
            return 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        res = longint'(e) << LOG_FRAC;
        for (int k = 0; k < LOG_FRAC; k++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                res = res | (64'd1 << (LOG_FRAC - 1 - k));
            end
        end
        return res;
    endfunction

    function automatic kin_t kinematics_of(logic signed [CB-1:0] e, logic signed [CB-1:0] px,
                                           logic signed [CB-1:0] py, logic signed [CB-1:0] pz);
        kin_t r;
        longint unsigned ax, ay, az, ae, st, s, pt, pq8, la, lb, d, eta_abs;
        longint x, y, z, nx, ny, theta;
        ax = (px < 0) ? -longint'(px) : longint'(px);
        ay = (py < 0) ? -longint'(py) : longint'(py);
        az = (pz < 0) ? -longint'(pz) : longint'(pz);
        ae = (e < 0) ? -longint'(e) : longint'(e);
        st = ax * ax + ay * ay;
        s = st + az * az;
        r = '0;
        r.mass = MASS_W'(ae * ae - s);
        if (s == 0)
        begin
            r.zero = 1'b1;
            return r;
        end
        pt = root_scaled(st, 8);
        pq8 = root_scaled(s, 8);
        r.mag = MAG_W'(root_scaled(s, 4));
        // vectoring CORDIC towards the beam axis
        x = longint'(az << 8);
        y = longint'(pt);
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + atan_entry(5'(i));
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - atan_entry(5'(i));
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            z = 0;
        if (z > ANGLE_HALF_PI)
            z = ANGLE_HALF_PI;
        theta = (pz < 0) ? longint'(ANGLE_PI) - z : z;
        r.angle = ANGLE_W'((theta + 8192) >>> 14);
        if (pt == 0)
            eta_abs = longint'(ETA_MAX) + 1;
        else
        begin
            la = log2_q20(pq8 + (az << 8));
            lb = log2_q20(pt);
            d = (la > lb) ? la - lb : 0;
            eta_abs = (d * longint'(LN2_Q30) + (64'd1 << 37)) >> 38;
        end
        if (eta_abs > ETA_MAX)
        begin
            eta_abs = ETA_MAX;
            r.sat = 1'b1;
        end
        r.eta = (pz < 0) ? -ETA_W'(eta_abs) : ETA_W'(eta_abs);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // present one word and hold it until accepted; valid drops only for an idle gap
    task automatic send_vector(logic signed [CB-1:0] e, logic signed [CB-1:0] px,
                               logic signed [CB-1:0] py, logic signed [CB-1:0] pz);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
        energy_value <= e;
        momentum_x <= px;
        momentum_y <= py;
        momentum_z <= pz;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        kin_expected.push_back(kinematics_of(e, px, py, pz));
        @(negedge clk);
    endtask

    // receiver side: stall bursts, off in the calm tail
    always
    begin
        @(negedge clk);
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // result checker: oldest expectation first
    always @(posedge clk)
    begin
        kin_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (kin_expected.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                error_count++;
            end
            else
            begin
                want = kin_expected.pop_front();
                if (momentum_magnitude !== want.mag)
                    report_mismatch("momentum_magnitude", momentum_magnitude, want.mag);
                if (polar_angle !== want.angle)
                    report_mismatch("polar_angle", polar_angle, want.angle);
                if (pseudorapidity !== want.eta)
                    report_mismatch("pseudorapidity", pseudorapidity, want.eta);
                if (mass_squared !== want.mass)
                    report_mismatch("mass_squared", mass_squared, want.mass);
                if (zero_momentum !== want.zero)
                    report_mismatch("zero_momentum", zero_momentum, want.zero);
                if (eta_saturated !== want.sat)
                    report_mismatch("eta_saturated", eta_saturated, want.sat);
            end
        end
    end

    function automatic logic signed [CB-1:0] random_component();
        case ($urandom_range(0, 5))
            0: return CB'($urandom_range(0, 15)) - 16'sd8;           // near zero
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return 16'sd0;
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic vec_row_t row(int e, int px, int py, int pz);
        vec_row_t r;
        r.e = CB'(e);
        r.px = CB'(px);
        r.py = CB'(py);
        r.pz = CB'(pz);
        r.has_fixed = 1'b0;
        r.fixed = '0;
        return r;
    endfunction

    // expected values read straight off the definition
    function automatic vec_row_t fixed_row(int e, int px, int py, int pz, kin_t k);
        vec_row_t r;
        r = row(e, px, py, pz);
        r.has_fixed = 1'b1;
        r.fixed = k;
        return r;
    endfunction

    initial
    begin
        vec_row_t directed[$];
        logic signed [CB-1:0] pa, pb, pc;
        kin_t k;

        // zero momentum: only the mass survives
        directed.push_back(fixed_row(0, 0, 0, 0, '{0, 0, 0, 0, 1'b1, 1'b0}));
        directed.push_back(fixed_row(-32768, 0, 0, 0, '{0, 0, 0, 33'sd1073741824, 1'b1, 1'b0}));
        directed.push_back(fixed_row(32767, 0, 0, 0, '{0, 0, 0, 33'sd1073676289, 1'b1, 1'b0}));
        // along the beam: eta saturates, angle 0 or pi
        directed.push_back(fixed_row(0, 0, 0, 1, '{20'd16, 0, 16'sd32767, -33'sd1, 1'b0, 1'b1}));
        directed.push_back(fixed_row(0, 0, 0, -1,
                                     '{20'd16, 17'd65536, -16'sd32767, -33'sd1, 1'b0, 1'b1}));
        directed.push_back(fixed_row(0, 0, 0, -32768,
                                     '{20'd524288, 17'd65536, -16'sd32767,
                                       -33'sd1073741824, 1'b0, 1'b1}));
        // transverse: eta 0, angle pi/2
        directed.push_back(row(5, 3, 0, 0));
        directed.push_back(row(0, 0, -32768, 0));
        // all extremes: largest |p| and most negative mass
        directed.push_back(row(0, -32768, -32768, -32768));
        directed.push_back(row(32767, 32767, 32767, 32767));
        directed.push_back(row(-1, 1, 1, 1));
        directed.push_back(row(100, 1, 0, 32767));     // forward, large eta
        directed.push_back(row(100, 0, -1, -32768));   // backward, large eta
        directed.push_back(row(-32768, 1, -1, 32767));
        directed.push_back(row(1, 3, 4, 12));
        directed.push_back(row(-21846, 21845, -21846, -21846));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            k = kinematics_of(directed[i].e, directed[i].px, directed[i].py, directed[i].pz);
            if (directed[i].has_fixed && k !== directed[i].fixed)
                report_mismatch("table entry", i, i);
            send_vector(directed[i].e, directed[i].px, directed[i].py, directed[i].pz);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 150)
                calm_tail = 1'b1;
            pa = random_component();
            pb = random_component();
            pc = random_component();
            // mostly general vectors, some along an axis
            if ($urandom_range(0, 9) == 0)
            begin
                pa = '0;
                pb = '0;
            end
            send_vector(CB'($urandom), pa, pb, pc);
        end
        in_valid <= 1'b0;
        feeding_done = 1'b1;
    end

    // drain, settle for the pipe latency, then conclude
    initial
    begin
        wait (feeding_done);
        while (kin_expected.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
